// ----- design/tosm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tosm_pkg;

    localparam int NUM_STREAMS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int MAX_RESULTS     = 64;

    localparam int DTS_W  = 33;
    localparam int UNIT_W = 32;
    localparam int TAG_W  = 16;
    localparam int KIND_W = 2;
    localparam int SLOT_W = 6;   // holds any slot number up to the largest stream count
    localparam int REQ_W  = 4;
    localparam int CIDX_W = 2;

    localparam logic [DTS_W-1:0] DELAY_RESET = 33'd90000;

    localparam logic [KIND_W-1:0] KIND_MEDIA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ALT   = 2'd3;

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_DROPPED  = 1'b1;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_FLUSH   = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_DELAY    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_REQUIRED = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ORDER    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // running best heads, passed cell to cell
    typedef struct packed {
        logic              m_found;
        logic [DTS_W-1:0]  m_key;
        logic [SLOT_W-1:0] m_slot;
        logic [DTS_W-1:0]  m_dts;
        logic [TAG_W-1:0]  m_tag;
        logic              c_found;
        logic [DTS_W-1:0]  c_dts;
        logic [KIND_W-1:0] c_kind;
        logic [TAG_W-1:0]  c_tag;
    } tok_t;

    typedef struct packed {
        logic              en;
        logic [KIND_W-1:0] kind;
        logic [DTS_W-1:0]  dts;
        logic [UNIT_W-1:0] unit;
        logic [TAG_W-1:0]  tag;
    } push_t;

    typedef struct packed {
        logic              clear;
        logic              pop_media;
        logic [SLOT_W-1:0] media_slot;
        logic              pop_ctrl;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic ok;
        logic full;
    } cell_stat_t;

endpackage
`default_nettype wire

// ----- design/tosm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tosm_cell #(
    parameter int IDX         = 0,
    parameter int QUEUE_DEPTH = tosm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [tosm_pkg::DTS_W-1:0] delay_ticks,
    input  wire logic                       order_mode,
    input  wire tosm_pkg::push_t            push,
    input  wire tosm_pkg::cmd_t             cmd,
    input  wire tosm_pkg::tok_t             tok_in,
    output tosm_pkg::tok_t                  tok_out,
    output tosm_pkg::cell_stat_t            stat
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [tosm_pkg::DTS_W-1:0]  dts_mem_reg  [QUEUE_DEPTH];
    logic [tosm_pkg::UNIT_W-1:0] unit_mem_reg [QUEUE_DEPTH];
    logic [tosm_pkg::KIND_W-1:0] kind_mem_reg [QUEUE_DEPTH];
    logic [tosm_pkg::TAG_W-1:0]  tag_mem_reg  [QUEUE_DEPTH];
    logic [tosm_pkg::DTS_W-1:0]  tail_dts_reg;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [FW-1:0]               mark_reg, mark_next;
    logic                        active_reg, active_next;
    tosm_pkg::tok_t              tok_reg, tok_next;

    logic [tosm_pkg::DTS_W-1:0] head_key;
    logic [tosm_pkg::DTS_W-1:0] span;
    logic                       span_ok;
    logic                       do_pop;

    assign span     = tail_dts_reg - dts_mem_reg[0];
    assign span_ok  = (tail_dts_reg >= dts_mem_reg[0]) && (span >= delay_ticks);
    assign head_key = order_mode ? tosm_pkg::DTS_W'(unit_mem_reg[0]) : dts_mem_reg[0];

    assign stat.active = active_reg;
    assign stat.full   = (fill_reg == FW'(QUEUE_DEPTH));
    assign stat.ok     = !active_reg || ((fill_reg != '0) && (span_ok || mark_reg != '0));

    // merge own head into the token from the lower neighbor
    always_comb
    begin
        tok_next = tok_in;
        if (active_reg && kind_mem_reg[0] == tosm_pkg::KIND_MEDIA &&
            (!tok_in.m_found || head_key < tok_in.m_key))
        begin
            tok_next.m_found = 1'b1;
            tok_next.m_key   = head_key;
            tok_next.m_slot  = tosm_pkg::SLOT_W'(IDX);
            tok_next.m_dts   = dts_mem_reg[0];
            tok_next.m_tag   = tag_mem_reg[0];
        end
        // later slot wins a tie
        if (active_reg && (!tok_in.c_found || dts_mem_reg[0] >= tok_in.c_dts))
        begin
            tok_next.c_found = 1'b1;
            tok_next.c_dts   = dts_mem_reg[0];
            tok_next.c_kind  = kind_mem_reg[0];
            tok_next.c_tag   = tag_mem_reg[0];
        end
    end

    assign tok_out = tok_reg;

    always_comb
    begin
        fill_next   = fill_reg;
        mark_next   = mark_reg;
        active_next = active_reg;
        do_pop      = 1'b0;
        if (cmd.clear)
        begin
            fill_next   = '0;
            mark_next   = '0;
            active_next = 1'b0;
        end
        else if (push.en)
        begin
            fill_next   = fill_reg + FW'(1);
            mark_next   = (push.kind != tosm_pkg::KIND_MEDIA) ? mark_reg + FW'(1) : mark_reg;
            active_next = 1'b1;
        end
        else if (cmd.pop_media && cmd.media_slot == tosm_pkg::SLOT_W'(IDX))
        begin
            fill_next = fill_reg - FW'(1);
            do_pop    = 1'b1;
        end
        else if (cmd.pop_ctrl && active_reg)
        begin
            if (kind_mem_reg[0] == tosm_pkg::KIND_END)
            begin
                fill_next   = '0;
                mark_next   = '0;
                active_next = 1'b0;
            end
            else
            begin
                fill_next = fill_reg - FW'(1);
                mark_next = (mark_reg != '0) ? mark_reg - FW'(1) : mark_reg;
                do_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            mark_reg   <= '0;
            active_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            mark_reg   <= mark_next;
            active_reg <= active_next;
            tok_reg    <= tok_next;
        end
    end

    // head always at entry 0: pop shifts down, push writes at the fill level
    always_ff @(posedge clk)
    begin
        if (push.en && !cmd.clear)
        begin
            dts_mem_reg[fill_reg[IW-1:0]]  <= push.dts;
            unit_mem_reg[fill_reg[IW-1:0]] <= push.unit;
            kind_mem_reg[fill_reg[IW-1:0]] <= push.kind;
            tag_mem_reg[fill_reg[IW-1:0]]  <= push.tag;
            tail_dts_reg                   <= push.dts;
        end
        else if (do_pop)
        begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            begin
                dts_mem_reg[k]  <= dts_mem_reg[k+1];
                unit_mem_reg[k] <= unit_mem_reg[k+1];
                kind_mem_reg[k] <= kind_mem_reg[k+1];
                tag_mem_reg[k]  <= tag_mem_reg[k+1];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("fill above depth");
    a_mark_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        mark_reg <= fill_reg)
        else $error("marker count above fill");
    a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (fill_reg == '0 && mark_reg == '0))
        else $error("inactive slot holds packets");
`endif

endmodule
`default_nettype wire

// ----- design/timestamp_ordered_stream_mux.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | handshake              | word
// ---------+-----+------------------------+---------------------------------------
// s_*      | in  | s_tvalid / s_tready    | packet arrival or flush request
// m_*      | out | m_tvalid / m_tready    | released packet or drop notice
// cfg_*    | in  | cfg_valid / cfg_ready  | register write (index, data)
//
// An s_* word is taken only while the sequencer is idle. For each release the head
// comparison ripples one cell per cycle down the cell chain, then the release edge
// pops. An arrival holds the input through its releases and a last scan that finds
// nothing to release; a flush only clears the queues and leaves the sequencer idle.
// Reset clears all queues and control state; registers take their reset values.
// A stalled m_* output holds the sequencer before the next release.
module timestamp_ordered_stream_mux #(
    parameter int NUM_STREAMS = tosm_pkg::NUM_STREAMS_DEF,
    parameter int QUEUE_DEPTH = tosm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [87:0]                 s_tdata,  // stream_slot, pkt_kind, pkt_dts, pkt_unit, pkt_tag
    input  wire logic                        s_tuser,  // req_type
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [87:0]                      m_tdata,  // out_kind, out_dts, out_tag, out_unit
    output logic                             m_tuser,  // status
    output logic                             m_tlast,  // last_of_run
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tosm_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [tosm_pkg::DTS_W-1:0]  cfg_data
);

    localparam int ACT_W = $clog2(NUM_STREAMS + 1);
    localparam int CMP_W = (ACT_W > tosm_pkg::REQ_W) ? ACT_W : tosm_pkg::REQ_W;
    localparam int CNT_W = $clog2(NUM_STREAMS + 1);
    localparam int RES_W = $clog2(tosm_pkg::MAX_RESULTS + 1);

    // configuration
    logic [tosm_pkg::DTS_W-1:0] delay_reg;
    logic [tosm_pkg::REQ_W-1:0] required_reg;
    logic                       order_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= tosm_pkg::DELAY_RESET;
            required_reg <= '0;
            order_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tosm_pkg::CFG_DELAY:    delay_reg    <= cfg_data;
                tosm_pkg::CFG_REQUIRED: required_reg <= cfg_data[tosm_pkg::REQ_W-1:0];
                tosm_pkg::CFG_ORDER:    order_reg    <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // input word fields
    logic [2:0]                  in_slot;
    logic [tosm_pkg::KIND_W-1:0] in_kind, in_kind_st;
    logic [tosm_pkg::DTS_W-1:0]  in_dts;
    logic [tosm_pkg::UNIT_W-1:0] in_unit;
    logic [tosm_pkg::TAG_W-1:0]  in_tag;

    assign in_slot    = s_tdata[2:0];
    assign in_kind    = s_tdata[4:3];
    assign in_dts     = s_tdata[37:5];
    assign in_unit    = s_tdata[69:38];
    assign in_tag     = s_tdata[85:70];
    // kind code 3 behaves as an end marker
    assign in_kind_st = (in_kind == tosm_pkg::KIND_ALT) ? tosm_pkg::KIND_END : in_kind;

    // cell chain
    tosm_pkg::tok_t       tok_w  [NUM_STREAMS];
    tosm_pkg::cell_stat_t stat_w [NUM_STREAMS];
    tosm_pkg::push_t      push_w [NUM_STREAMS];
    tosm_pkg::cmd_t       cmd;
    logic [NUM_STREAMS-1:0] active_vec, ok_vec, full_vec;

    logic in_accept, is_flush, slot_full, drop;

    for (genvar i = 0; i < NUM_STREAMS; i++)
    begin : g_cell
        tosm_pkg::tok_t tok_src;
        if (i == 0)
        begin : g_first
            assign tok_src = '0;
        end
        else
        begin : g_rest
            assign tok_src = tok_w[i-1];
        end

        assign push_w[i].en   = in_accept && !is_flush && !drop && (in_slot == 3'(i));
        assign push_w[i].kind = in_kind_st;
        assign push_w[i].dts  = in_dts;
        assign push_w[i].unit = in_unit;
        assign push_w[i].tag  = in_tag;

        tosm_cell #(
            .IDX         (i),
            .QUEUE_DEPTH (QUEUE_DEPTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .delay_ticks (delay_reg),
            .order_mode  (order_reg),
            .push        (push_w[i]),
            .cmd         (cmd),
            .tok_in      (tok_src),
            .tok_out     (tok_w[i]),
            .stat        (stat_w[i])
        );

        assign active_vec[i] = stat_w[i].active;
        assign ok_vec[i]     = stat_w[i].ok;
        assign full_vec[i]   = stat_w[i].full;
    end

    // slots past the last cell act as full
    always_comb
    begin
        slot_full = 1'b1;
        for (int i = 0; i < NUM_STREAMS; i++)
        begin
            if (in_slot == 3'(i))
            begin
                slot_full = full_vec[i];
            end
        end
    end

    // release condition
    logic [ACT_W-1:0] nact;
    logic             rel_ready;

    assign nact      = ACT_W'($countones(active_vec));
    assign rel_ready = (nact != '0) &&
                       ((required_reg == '0) || (CMP_W'(nact) >= CMP_W'(required_reg))) &&
                       (&ok_vec);

    // sequencer
    tosm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [RES_W-1:0] res_cnt_reg;
    logic [tosm_pkg::UNIT_W-1:0] unit_cnt_reg;

    logic scan_done, can_release, rel_fire, fin_move, out_free, out_take;

    // pending result: held until we know whether it is the last one
    logic                        pend_valid_reg;
    logic                        pend_status_reg;
    logic [tosm_pkg::KIND_W-1:0] pend_kind_reg;
    logic [tosm_pkg::DTS_W-1:0]  pend_dts_reg;
    logic [tosm_pkg::TAG_W-1:0]  pend_tag_reg;
    logic [tosm_pkg::UNIT_W-1:0] pend_unit_reg;

    logic                        out_valid_reg;
    logic                        out_status_reg;
    logic                        out_last_reg;
    logic [tosm_pkg::KIND_W-1:0] out_kind_reg;
    logic [tosm_pkg::DTS_W-1:0]  out_dts_reg;
    logic [tosm_pkg::TAG_W-1:0]  out_tag_reg;
    logic [tosm_pkg::UNIT_W-1:0] out_unit_reg;

    tosm_pkg::tok_t best;
    assign best = tok_w[NUM_STREAMS-1];

    assign out_free    = !out_valid_reg || m_tready;
    assign scan_done   = (scan_cnt_reg == CNT_W'(NUM_STREAMS));
    assign can_release = rel_ready && (res_cnt_reg < RES_W'(tosm_pkg::MAX_RESULTS));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tosm_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tuser == tosm_pkg::REQ_ARRIVAL)
                begin
                    state_next = tosm_pkg::ST_SCAN;
                end
            end
            tosm_pkg::ST_SCAN:
            begin
                if (scan_done && !can_release)
                begin
                    state_next = tosm_pkg::ST_FINISH;
                end
            end
            tosm_pkg::ST_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = tosm_pkg::ST_IDLE;
                end
            end
            default: state_next = tosm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rel_fire = 1'b0;
        fin_move = 1'b0;
        case (state_reg)
            tosm_pkg::ST_IDLE:   s_tready = 1'b1;
            tosm_pkg::ST_SCAN:   rel_fire = scan_done && can_release &&
                                            (!pend_valid_reg || out_free);
            tosm_pkg::ST_FINISH: fin_move = pend_valid_reg && out_free;
            default:             ;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;
    assign is_flush  = (s_tuser == tosm_pkg::REQ_FLUSH);
    assign drop      = slot_full;
    assign out_take  = (rel_fire && pend_valid_reg) || fin_move;

    assign cmd.clear      = in_accept && is_flush;
    assign cmd.pop_media  = rel_fire && best.m_found;
    assign cmd.media_slot = best.m_slot;
    assign cmd.pop_ctrl   = rel_fire && !best.m_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tosm_pkg::ST_IDLE;
            scan_cnt_reg   <= '0;
            res_cnt_reg    <= '0;
            unit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept || rel_fire)
            begin
                scan_cnt_reg <= '0;
            end
            else if (state_reg == tosm_pkg::ST_SCAN && !scan_done)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (in_accept && !is_flush)
            begin
                res_cnt_reg    <= drop ? RES_W'(1) : '0;
                pend_valid_reg <= drop;
            end
            else if (rel_fire)
            begin
                res_cnt_reg    <= res_cnt_reg + RES_W'(1);
                unit_cnt_reg   <= unit_cnt_reg + tosm_pkg::UNIT_W'(1);
                pend_valid_reg <= 1'b1;
            end
            else if (fin_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !is_flush && drop)
        begin
            pend_status_reg <= tosm_pkg::STATUS_DROPPED;
            pend_kind_reg   <= tosm_pkg::KIND_MEDIA;
            pend_dts_reg    <= '0;
            pend_tag_reg    <= '0;
            pend_unit_reg   <= '0;
        end
        else if (rel_fire)
        begin
            pend_status_reg <= tosm_pkg::STATUS_RELEASED;
            pend_kind_reg   <= best.m_found ? tosm_pkg::KIND_MEDIA : best.c_kind;
            pend_dts_reg    <= best.m_found ? best.m_dts : best.c_dts;
            pend_tag_reg    <= best.m_found ? best.m_tag : best.c_tag;
            pend_unit_reg   <= unit_cnt_reg;
        end
        if (out_take)
        begin
            out_status_reg <= pend_status_reg;
            out_kind_reg   <= pend_kind_reg;
            out_dts_reg    <= pend_dts_reg;
            out_tag_reg    <= pend_tag_reg;
            out_unit_reg   <= pend_unit_reg;
            out_last_reg   <= fin_move;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_unit_reg, out_tag_reg, out_dts_reg, out_kind_reg};

`ifndef NO_ASSERTIONS
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tosm_pkg::ST_IDLE |-> !pend_valid_reg)
        else $error("result pending while idle");
    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rel_fire |-> res_cnt_reg < RES_W'(tosm_pkg::MAX_RESULTS))
        else $error("release past result cap");
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == tosm_pkg::STATUS_DROPPED) |-> m_tdata == '0)
        else $error("drop notice carries data");
    a_release_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rel_fire |-> (rel_ready && (best.m_found || best.c_found)))
        else $error("release without a head");
`endif

endmodule
`default_nettype wire

// ----- tb/tosm_checker.sv -----
`timescale 1ns / 1ps
module tosm_checker
    import tosm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [87:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [87:0]       m_tdata,
    input  logic              m_tuser,
    input  logic              m_tlast,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [DTS_W-1:0]  cfg_data,
    output int                fail_count,
    output int                pending
);

    localparam int NS        = NUM_STREAMS_DEF;
    localparam int QD        = QUEUE_DEPTH_DEF;
    localparam int EXP_DEPTH = 4096;

    typedef struct packed {
        logic              status;
        logic [KIND_W-1:0] kind;
        logic [DTS_W-1:0]  dts;
        logic [TAG_W-1:0]  tag;
        logic [UNIT_W-1:0] unit;
        logic              last;
    } release_t;

    // expected results in order, ring of words
    release_t exp_mem [EXP_DEPTH];
    int       exp_wr;
    int       exp_rd;

    // mirrored queues and slot state
    logic [DTS_W-1:0]  q_dts  [NS][QD];
    logic [UNIT_W-1:0] q_unit [NS][QD];
    logic [KIND_W-1:0] q_kind [NS][QD];
    logic [TAG_W-1:0]  q_tag  [NS][QD];
    int                head   [NS];
    int                fill   [NS];
    int                markers[NS];
    bit                active [NS];
    logic [UNIT_W-1:0] unit_ctr;

    logic [DTS_W-1:0]  delay_ticks;
    logic [3:0]        need_streams;
    logic              by_unit;

    assign pending = exp_wr - exp_rd;

    function automatic int slot_entry(int s, int k);
        return (head[s] + k) % QD;
    endfunction

    function automatic void clear_slot(int s);
        head[s]    = 0;
        fill[s]    = 0;
        markers[s] = 0;
        active[s]  = 0;
    endfunction

    function automatic bit can_release();
        int nact;
        logic [DTS_W-1:0] hd, tl;
        nact = 0;
        for (int s = 0; s < NS; s++)
            if (active[s])
                nact++;
        if (nact == 0)
            return 0;
        if (need_streams != 0 && nact < need_streams)
            return 0;
        for (int s = 0; s < NS; s++)
        begin
            if (!active[s])
                continue;
            if (fill[s] == 0)
                return 0;
            hd = q_dts[s][slot_entry(s, 0)];
            tl = q_dts[s][slot_entry(s, fill[s] - 1)];
            // a tail older than the head never satisfies the span
            if ((tl < hd || (tl - hd) < delay_ticks) && markers[s] == 0)
                return 0;
        end
        return 1;
    endfunction

    function automatic release_t release_next();
        release_t r;
        bit found;
        int best, e;
        logic [DTS_W-1:0] key, best_key;
        found = 0;
        best = 0;
        best_key = '0;
        r = '0;
        for (int s = 0; s < NS; s++)
        begin
            if (!active[s])
                continue;
            e = slot_entry(s, 0);
            if (q_kind[s][e] != KIND_MEDIA)
                continue;
            key = by_unit ? DTS_W'(q_unit[s][e]) : q_dts[s][e];
            if (!found || key < best_key)
            begin
                found = 1;
                best_key = key;
                best = s;
            end
        end
        if (found)
        begin
            e = slot_entry(best, 0);
            r.kind = KIND_MEDIA;
            r.dts  = q_dts[best][e];
            r.tag  = q_tag[best][e];
            head[best] = (head[best] + 1) % QD;
            fill[best]--;
        end
        else
        begin
            // all heads are markers: merge, latest dts wins, ties to higher slot
            for (int s = 0; s < NS; s++)
            begin
                if (!active[s])
                    continue;
                e = slot_entry(s, 0);
                if (!found || q_dts[s][e] >= r.dts)
                begin
                    found  = 1;
                    r.dts  = q_dts[s][e];
                    r.kind = q_kind[s][e];
                    r.tag  = q_tag[s][e];
                end
            end
            for (int s = 0; s < NS; s++)
            begin
                if (!active[s])
                    continue;
                e = slot_entry(s, 0);
                if (q_kind[s][e] == KIND_END)
                    clear_slot(s);
                else
                begin
                    head[s] = (head[s] + 1) % QD;
                    fill[s]--;
                    if (markers[s] > 0)
                        markers[s]--;
                end
            end
        end
        r.status = STATUS_RELEASED;
        r.unit = unit_ctr;
        unit_ctr = unit_ctr + 1'b1;
        return r;
    endfunction

    function automatic void predict_word(logic req, logic [87:0] d);
        release_t run [MAX_RESULTS];
        release_t r;
        int n, s, e;
        logic [KIND_W-1:0] k;
        n = 0;
        if (req == REQ_FLUSH)
        begin
            for (int i = 0; i < NS; i++)
                clear_slot(i);
            return;
        end
        s = int'(d[2:0]);
        k = d[4:3];
        if (k == KIND_ALT)
            k = KIND_END;
        if (fill[s] >= QD)
        begin
            r = '0;
            r.status = STATUS_DROPPED;
            run[n] = r;
            n++;
        end
        else
        begin
            e = slot_entry(s, fill[s]);
            q_dts[s][e]  = d[37:5];
            q_unit[s][e] = d[69:38];
            q_tag[s][e]  = d[85:70];
            q_kind[s][e] = k;
            fill[s]++;
            if (k != KIND_MEDIA)
                markers[s]++;
            active[s] = 1;
        end
        while (n < MAX_RESULTS && can_release())
        begin
            run[n] = release_next();
            n++;
        end
        if (n > 0)
            run[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            exp_mem[exp_wr % EXP_DEPTH] = run[i];
            exp_wr++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        release_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                clear_slot(i);
            unit_ctr     = '0;
            delay_ticks  = DELAY_RESET;
            need_streams = '0;
            by_unit      = 1'b0;
            fail_count   = 0;
            exp_wr       = 0;
            exp_rd       = 0;
        end
        else
        begin
            // results first: a word accepted now cannot have produced them
            if (m_tvalid && m_tready)
            begin
                if (exp_wr == exp_rd)
                    report_mismatch("unexpected output word", m_tdata[63:0], 64'd0);
                else
                begin
                    want = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[1:0] != want.kind)
                        report_mismatch("out_kind", m_tdata[1:0], want.kind);
                    if (m_tdata[34:2] != want.dts)
                        report_mismatch("out_dts", m_tdata[34:2], want.dts);
                    if (m_tdata[50:35] != want.tag)
                        report_mismatch("out_tag", m_tdata[50:35], want.tag);
                    if (m_tdata[82:51] != want.unit)
                        report_mismatch("out_unit", m_tdata[82:51], want.unit);
                    if (m_tlast != want.last)
                        report_mismatch("last_of_run", m_tlast, want.last);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DELAY:    delay_ticks  = cfg_data;
                    CFG_REQUIRED: need_streams = cfg_data[3:0];
                    CFG_ORDER:    by_unit      = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata);
        end
    end

endmodule

// ----- tb/tb_timestamp_ordered_stream_mux.sv -----
`timescale 1ns / 1ps
module tb_timestamp_ordered_stream_mux;
    import tosm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [87:0]       s_tdata;   // stream_slot, pkt_kind, pkt_dts, pkt_unit, pkt_tag, pad
    logic              s_tuser;   // req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [87:0]       m_tdata;   // out_kind, out_dts, out_tag, out_unit, pad
    logic              m_tuser;   // status
    logic              m_tlast;   // last_of_run
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [DTS_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int cycles;

    // receiver and sender behavior knobs, changed by the stimulus process
    bit calm_sink;
    bit sink_hold_req;
    int hold_left;
    bit calm_source;

    // per-slot running timestamps keep streams mostly well ordered
    logic [DTS_W-1:0] slot_dts[8];

    timestamp_ordered_stream_mux dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tosm_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: random stalls, calm stretches, and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (sink_hold_req && hold_left == 0)
        begin
            hold_left <= 400;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (calm_sink)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 33);
    end

    // sender gap before the next word; none during calm stretches
    task automatic idle_gap();
        int n;
        n = 0;
        if (!calm_source)
            while ($urandom_range(99) < 33)
                n++;
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_word(logic req, logic [2:0] slot, logic [1:0] kind,
                             logic [32:0] dts, logic [31:0] unit, logic [15:0] tag);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, tag, unit, dts, kind, slot};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [DTS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // let everything drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_mode(logic [32:0] dly, logic [3:0] need, logic ord);
        settle();
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_REQUIRED, {29'd0, need});
        write_reg(CFG_ORDER, {32'd0, ord});
    endtask

    // one random word: mostly media on the phase's slots with advancing dts
    task automatic random_word(logic [7:0] slot_mask);
        logic [2:0]  slot;
        logic [1:0]  kind;
        logic [32:0] dts;
        if ($urandom_range(99) < 3)
        begin
            send_word(REQ_FLUSH, 3'($urandom), 2'($urandom), {1'b0, $urandom}, $urandom,
                      16'($urandom));
            return;
        end
        do
            slot = 3'($urandom_range(7));
        while (!slot_mask[slot]);
        kind = ($urandom_range(99) < 80) ? KIND_MEDIA : 2'($urandom_range(1, 3));
        if ($urandom_range(99) < 5)
            dts = {1'($urandom), $urandom};
        else
        begin
            slot_dts[slot] = slot_dts[slot] + 33'($urandom_range(60));
            dts = slot_dts[slot];
        end
        send_word(REQ_ARRIVAL, slot, kind, dts, $urandom, 16'($urandom));
    endtask

    task automatic random_phase(int n, logic [7:0] slot_mask);
        for (int i = 0; i < n; i++)
            random_word(slot_mask);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cycles        = 0;
        calm_sink     = 1'b0;
        calm_source   = 1'b0;
        sink_hold_req = 1'b0;
        foreach (slot_dts[i])
            slot_dts[i] = 33'($urandom_range(1000));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero delay; after the first release the emptied slot 0 stays active and holds back later arrivals
        set_mode(33'd0, 4'd0, 1'b0);
        send_word(REQ_ARRIVAL, 3'd0, KIND_MEDIA, 33'd0, 32'd0, 16'd0);
        send_word(REQ_ARRIVAL, 3'd7, KIND_MEDIA, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // markers of every kind, including the alias code for an end marker
        send_word(REQ_ARRIVAL, 3'd1, KIND_RESET, 33'd500, 32'd3, 16'h1234);
        send_word(REQ_ARRIVAL, 3'd2, KIND_END, 33'd500, 32'd4, 16'h4321);
        send_word(REQ_ARRIVAL, 3'd3, KIND_ALT, 33'd400, 32'd5, 16'hAAAA);
        send_word(REQ_FLUSH, 3'd0, KIND_MEDIA, 33'd0, 32'd0, 16'd0);

        // span gating, negative span, media ties and merged control ties
        set_mode(33'd100, 4'd2, 1'b1);
        send_word(REQ_ARRIVAL, 3'd4, KIND_MEDIA, 33'd1000, 32'd9, 16'h0011);
        send_word(REQ_ARRIVAL, 3'd5, KIND_MEDIA, 33'd1000, 32'd9, 16'h0022);
        send_word(REQ_ARRIVAL, 3'd4, KIND_MEDIA, 33'd900, 32'd7, 16'h0033);
        send_word(REQ_ARRIVAL, 3'd4, KIND_MEDIA, 33'd1200, 32'd2, 16'h0044);
        send_word(REQ_ARRIVAL, 3'd5, KIND_RESET, 33'd1300, 32'd1, 16'h0055);
        send_word(REQ_ARRIVAL, 3'd4, KIND_RESET, 33'd1300, 32'd1, 16'h0066);
        send_word(REQ_ARRIVAL, 3'd5, KIND_END, 33'd1400, 32'd1, 16'h0077);
        send_word(REQ_ARRIVAL, 3'd4, KIND_END, 33'd1400, 32'd1, 16'h0088);
        send_word(REQ_FLUSH, 3'd0, KIND_MEDIA, 33'd0, 32'd0, 16'd0);

        // stream count above the slot count never releases: fill one queue past full
        set_mode(33'd0, 4'd15, 1'b0);
        for (int i = 0; i < 10; i++)
            send_word(REQ_ARRIVAL, 3'd6, KIND_MEDIA, 33'(i), 32'(i), 16'(i));
        send_word(REQ_FLUSH, 3'd0, KIND_MEDIA, 33'd0, 32'd0, 16'd0);

        // random phases over several settings
        set_mode(33'd100, 4'd0, 1'b0);
        calm_sink   = 1'b1;
        calm_source = 1'b1;
        random_phase(18, 8'b0000_0111);
        calm_sink   = 1'b0;
        calm_source = 1'b0;

        set_mode(33'd0, 4'd2, 1'b1);
        random_phase(18, 8'b1010_0000);

        set_mode(33'h1_FFFF_FFFF, 4'd0, 1'b0);
        random_phase(16, 8'b0001_1000);

        set_mode(33'd50, 4'd3, 1'b1);
        random_phase(18, 8'b0100_1011);

        // long receiver hold-off while words keep coming: the block backs up
        set_mode(33'd0, 4'd0, 1'b0);
        sink_hold_req = 1'b1;
        wait (hold_left > 0);
        sink_hold_req = 1'b0;
        random_phase(18, 8'b0000_0011);

        set_mode(33'd20, 4'd8, 1'b0);
        random_phase(18, 8'hFF);

        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tosm_pkg.sv
design/tosm_cell.sv
design/timestamp_ordered_stream_mux.sv
tb/tosm_checker.sv
tb/tb_timestamp_ordered_stream_mux.sv
